@@ hw/rtl/quadrature_knob_decoder_assert.svh @@
// Assertion macros for the quadrature knob decoder RTL.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef QUADRATURE_KNOB_DECODER_ASSERT_SVH
`define QUADRATURE_KNOB_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is held.
`define QKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also runs during reset.
`define QKD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QKD_ASSERT(label, prop, msg)
`define QKD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ hw/rtl/qkd_pkg.sv @@
// Shared types and constants of the quadrature knob decoder.
// Used by qkd_debounce and quadrature_knob_decoder; depends on nothing.
package qkd_pkg;

  localparam int COUNT_BITS = 32;
  localparam int TICK_BITS  = 8;
  localparam int LIMIT_BITS = 32;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DIRECTION_SWAP = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_UPPER_LIMIT    = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_LOWER_LIMIT    = 2'd3;

  localparam logic signed [LIMIT_BITS-1:0] UPPER_LIMIT_RESET = 32'sd100;
  localparam logic signed [LIMIT_BITS-1:0] LOWER_LIMIT_RESET = -32'sd100;

  typedef enum logic [1:0] {
    MODE_CHECK = 2'd0,
    MODE_READY = 2'd1,
    MODE_PHA   = 2'd2,
    MODE_PHB   = 2'd3
  } mode_t;

  // Step codes.
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // Mark codes.
  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_HIGH = 2'd1;
  localparam logic [1:0] MARK_LOW  = 2'd2;
  localparam logic [1:0] MARK_ZERO = 2'd3;

  // Latched event codes.
  localparam logic [2:0] EVT_NONE  = 3'd0;
  localparam logic [2:0] EVT_LEFT  = 3'd1;
  localparam logic [2:0] EVT_RIGHT = 3'd2;
  localparam logic [2:0] EVT_HIGH  = 3'd3;
  localparam logic [2:0] EVT_LOW   = 3'd4;
  localparam logic [2:0] EVT_ZERO  = 3'd5;

  // Debounce result of one phase for the current sample.
  typedef struct packed {
    logic level;  // accepted level after this sample
    logic hit;    // a new level was accepted by this sample
  } dbn_t;

endpackage

@@ hw/rtl/quadrature_knob_decoder.sv @@
// Top level of the debounced quadrature knob decoder with a signed step counter.
// Depends on qkd_pkg, qkd_debounce and quadrature_knob_decoder_assert.svh.
//
// Usage:
//   The input channel (in_*) carries one item per pin sample tick. in_tuser is the
//   item kind: 0 is a sample whose pin levels sit in in_tdata, 1 clears the count.
//   Every item produces exactly one result item on the output channel (out_*):
//   the step taken by this item, the limit or zero mark, the latched event and
//   the signed step count after the item.
//   An item accepted at one clock edge shows its result on out_tdata with
//   out_tvalid high right after that edge. Throughput is one item per cycle
//   while the receiver takes results; the debounce, state machine, 32-bit add
//   and limit compares all sit between the current state and the result register.
//   The single result register is the only buffer. While it holds a result the
//   receiver has not taken, in_tready follows out_tready, so a new item is
//   taken in the same cycle the old result leaves. A stalled receiver holds
//   off the input after one item.
//   Reset (rst_n low, synchronous) empties the result register, returns the
//   state machine to waiting for both phases high, zeroes the count, the
//   debounce state and the event latch, and loads the register defaults:
//   debounce 0, no swap, upper limit 100, lower limit -100.
//   Configuration writes are taken at any edge with cfg_we high and should
//   only be made while no item is in flight.
module quadrature_knob_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] level_a_in, [1] level_b_in
  input  logic [0:0]                        in_tuser,   // [0] kind
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [39:0]                       out_tdata,  // [1:0] turn, [3:2] mark,
                                                        // [6:4] last_event, [38:7] count_out
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [qkd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [qkd_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int CB = qkd_pkg::COUNT_BITS;

  // Configuration registers.
  logic [qkd_pkg::TICK_BITS-1:0]          ticks_r;
  logic                                   swap_r;
  logic signed [qkd_pkg::LIMIT_BITS-1:0]  upper_r;
  logic signed [qkd_pkg::LIMIT_BITS-1:0]  lower_r;

  // Decoder state.
  qkd_pkg::mode_t          mode_r, mode_nxt;
  logic                    chg_a_r, chg_a_nxt;
  logic                    chg_b_r, chg_b_nxt;
  logic [2:0]              evt_r, evt_nxt;
  logic signed [CB-1:0]    count_r, count_nxt;

  // Result register.
  logic                    out_valid_r;
  logic [39:0]             out_data_r;

  logic                    in_fire;
  logic                    kind;
  logic                    sample_en;
  qkd_pkg::dbn_t           dbn_a, dbn_b;
  logic                    chg_a, chg_b;
  logic                    do_step, step_up;
  logic signed [CB-1:0]    stepped;
  logic [1:0]              turn_nxt, mark_nxt;

  assign kind      = in_tuser[0];
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign sample_en = in_fire && !kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= '0;
      swap_r  <= 1'b0;
      upper_r <= qkd_pkg::UPPER_LIMIT_RESET;
      lower_r <= qkd_pkg::LOWER_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        qkd_pkg::CFG_DEBOUNCE_TICKS: ticks_r <= cfg_wdata[qkd_pkg::TICK_BITS-1:0];
        qkd_pkg::CFG_DIRECTION_SWAP: swap_r  <= cfg_wdata[0];
        qkd_pkg::CFG_UPPER_LIMIT:    upper_r <= cfg_wdata[qkd_pkg::LIMIT_BITS-1:0];
        qkd_pkg::CFG_LOWER_LIMIT:    lower_r <= cfg_wdata[qkd_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  qkd_debounce u_dbn_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .level     (in_tdata[0]),
    .ticks     (ticks_r),
    .res       (dbn_a)
  );

  qkd_debounce u_dbn_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .level     (in_tdata[1]),
    .ticks     (ticks_r),
    .res       (dbn_b)
  );

  // Pending change flags including anything accepted by this sample.
  assign chg_a = chg_a_r || dbn_a.hit;
  assign chg_b = chg_b_r || dbn_b.hit;

  // State machine: wait for both phases high, note the leading phase, then
  // step when the trailing phase follows. A repeat of the leading phase is a
  // glitch and drops back to ready. On a tie A wins in ready, else the trailing phase.
  always_comb begin
    mode_nxt  = mode_r;
    chg_a_nxt = chg_a;
    chg_b_nxt = chg_b;
    evt_nxt   = evt_r;
    do_step   = 1'b0;
    step_up   = 1'b0;
    unique case (mode_r)
      qkd_pkg::MODE_READY: begin
        if (chg_a) begin
          chg_a_nxt = 1'b0;
          mode_nxt  = qkd_pkg::MODE_PHA;
        end else if (chg_b) begin
          chg_b_nxt = 1'b0;
          mode_nxt  = qkd_pkg::MODE_PHB;
        end else begin
          evt_nxt = qkd_pkg::EVT_NONE;
        end
      end
      qkd_pkg::MODE_PHA: begin
        if (chg_b) begin
          chg_b_nxt = 1'b0;
          do_step   = 1'b1;
          step_up   = !swap_r;
          mode_nxt  = qkd_pkg::MODE_READY;
        end else if (chg_a) begin
          chg_a_nxt = 1'b0;
          mode_nxt  = qkd_pkg::MODE_READY;
        end
      end
      qkd_pkg::MODE_PHB: begin
        if (chg_a) begin
          chg_a_nxt = 1'b0;
          do_step   = 1'b1;
          step_up   = swap_r;
          mode_nxt  = qkd_pkg::MODE_READY;
        end else if (chg_b) begin
          chg_b_nxt = 1'b0;
          mode_nxt  = qkd_pkg::MODE_READY;
        end
      end
      qkd_pkg::MODE_CHECK: begin
        if (dbn_a.level && dbn_b.level) begin
          mode_nxt  = qkd_pkg::MODE_READY;
          chg_a_nxt = 1'b0;
          chg_b_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // Count update, step code and mark; high limit beats low limit beats zero.
    stepped   = step_up ? count_r + 1'b1 : count_r - 1'b1;
    turn_nxt  = qkd_pkg::TURN_NONE;
    mark_nxt  = qkd_pkg::MARK_NONE;
    count_nxt = count_r;
    if (do_step) begin
      count_nxt = stepped;
      turn_nxt  = step_up ? qkd_pkg::TURN_RIGHT : qkd_pkg::TURN_LEFT;
      evt_nxt   = step_up ? qkd_pkg::EVT_RIGHT : qkd_pkg::EVT_LEFT;
      priority if (stepped >= upper_r) begin
        mark_nxt = qkd_pkg::MARK_HIGH;
        evt_nxt  = qkd_pkg::EVT_HIGH;
      end else if (stepped <= lower_r) begin
        mark_nxt = qkd_pkg::MARK_LOW;
        evt_nxt  = qkd_pkg::EVT_LOW;
      end else if (stepped == '0) begin
        mark_nxt = qkd_pkg::MARK_ZERO;
        evt_nxt  = qkd_pkg::EVT_ZERO;
      end else begin
        mark_nxt = qkd_pkg::MARK_NONE;
      end
    end

    // A clear item only zeroes the count; everything else stands.
    if (kind) begin
      mode_nxt  = mode_r;
      chg_a_nxt = chg_a_r;
      chg_b_nxt = chg_b_r;
      evt_nxt   = evt_r;
      count_nxt = '0;
      turn_nxt  = qkd_pkg::TURN_NONE;
      mark_nxt  = qkd_pkg::MARK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= qkd_pkg::MODE_CHECK;
      chg_a_r <= 1'b0;
      chg_b_r <= 1'b0;
      evt_r   <= qkd_pkg::EVT_NONE;
      count_r <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      chg_a_r <= chg_a_nxt;
      chg_b_r <= chg_b_nxt;
      evt_r   <= evt_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {1'b0, count_nxt[31:0], evt_nxt, mark_nxt, turn_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "quadrature_knob_decoder_assert.svh"

  `QKD_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid, "result left after reset")
  `QKD_ASSERT(a_clear_zeroes, (in_fire && kind) |=> (count_r == '0), "clear did not zero count")
  `QKD_ASSERT(a_check_no_step, (in_fire && mode_r == qkd_pkg::MODE_CHECK) |=> (out_tdata[1:0] == qkd_pkg::TURN_NONE), "step while waiting for both high")
  `QKD_ASSERT(a_right_adds_one, (in_fire && turn_nxt == qkd_pkg::TURN_RIGHT) |=> (count_r == $past(count_r) + 1'b1), "right step did not add one")
  `QKD_ASSERT(a_idle_holds_mode, !in_fire |=> $stable(mode_r), "mode moved without an item")

endmodule

@@ hw/rtl/qkd_debounce.sv @@
// Debounce filter of one quadrature phase pin.
// Depends on qkd_pkg for widths and the dbn_t result struct.
module qkd_debounce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          sample_en,
  input  logic                          level,
  input  logic [qkd_pkg::TICK_BITS-1:0] ticks,
  output qkd_pkg::dbn_t                 res
);

  logic                          acc_r;
  logic [qkd_pkg::TICK_BITS-1:0] cnt_r;
  logic [qkd_pkg::TICK_BITS-1:0] cnt_nxt;
  logic [qkd_pkg::TICK_BITS-1:0] cnt_inc;

  // A differing sample bumps the counter; once it reaches the threshold the
  // new level is taken and the counter starts over.
  always_comb begin
    cnt_inc   = cnt_r + 1'b1;
    res.level = acc_r;
    res.hit   = 1'b0;
    cnt_nxt   = '0;
    if (level != acc_r) begin
      if (cnt_inc >= ticks) begin
        res.level = level;
        res.hit   = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 1'b0;
      cnt_r <= '0;
    end else if (sample_en) begin
      acc_r <= res.level;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ verif/tb_quadrature_knob_decoder.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the quadrature knob decoder: directed cases, a long
// debounce run, a receiver hold-off and randomized knob turns. Needs qkd_pkg and the RTL.
module tb_quadrature_knob_decoder;

  localparam int HALF_PERIOD   = 6;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 3;

  // Item kinds carried on in_tuser.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct {
    logic [1:0]                            turn;
    logic [1:0]                            mark;
    logic [2:0]                            evt;
    logic signed [qkd_pkg::COUNT_BITS-1:0] count;
  } knob_result_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [7:0]                        in_tdata   = '0;  // [0] level_a_in, [1] level_b_in
  logic [0:0]                        in_tuser   = '0;  // [0] kind
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [39:0]                       out_tdata;        // [1:0] turn, [3:2] mark,
                                                       // [6:4] last_event, [38:7] count_out
  logic                              cfg_we     = 1'b0;
  logic [qkd_pkg::CFG_ADDR_BITS-1:0] cfg_addr   = '0;
  logic [qkd_pkg::CFG_DATA_BITS-1:0] cfg_wdata  = '0;

  quadrature_knob_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // The decoder as the testbench sees it: register copies and the full state,
  // advanced once per accepted item.
  bit [7:0]                              ticks_needed;
  bit                                    swap_sense;
  logic signed [31:0]                    upper_bound;
  logic signed [31:0]                    lower_bound;
  qkd_pkg::mode_t                        knob_mode;
  bit                                    level_a, level_b;
  bit                                    moved_a, moved_b;
  bit [7:0]                              bounce_a, bounce_b;
  logic [2:0]                            latched_event;
  logic signed [qkd_pkg::COUNT_BITS-1:0] step_total;

  // Results still owed by the block, oldest first.
  knob_result_t expected_results[$];

  // Idling controls. The sender's rate is only read by the sending process; the
  // receiver's rate and the hold-off request are written with nonblocking
  // assignments so the ready process sees them on a clean edge.
  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  int unsigned hold_req           = 0;
  int unsigned hold_seen          = 0;
  int unsigned hold_left          = 0;

  // Bookkeeping for the verdict and the closing summary.
  int error_count     = 0;
  int items_sent      = 0;
  int clears_sent     = 0;
  int results_checked = 0;
  int steps_seen      = 0;
  int settings_used   = 0;
  int marks_seen[4]   = '{0, 0, 0, 0};

  task automatic reset_model();
    ticks_needed  = '0;
    swap_sense    = 1'b0;
    upper_bound   = qkd_pkg::UPPER_LIMIT_RESET;
    lower_bound   = qkd_pkg::LOWER_LIMIT_RESET;
    knob_mode     = qkd_pkg::MODE_CHECK;
    level_a       = 1'b0;
    level_b       = 1'b0;
    moved_a       = 1'b0;
    moved_b       = 1'b0;
    bounce_a      = '0;
    bounce_b      = '0;
    latched_event = qkd_pkg::EVT_NONE;
    step_total    = '0;
  endtask

  // One phase of debounce: a differing pin level is taken over once it has been
  // seen ticks_needed times in a row; with 0 or 1 a single sample does it.
  task automatic debounce_phase(input bit pin, inout bit level, inout bit [7:0] run,
                                inout bit moved);
    if (pin != level) begin
      run = run + 8'd1;
      if (run >= ticks_needed) begin
        moved = 1'b1;
        level = pin;
        run   = '0;
      end
    end else begin
      run = '0;
    end
  endtask

  // Moves the count by one and works out the mark. The high limit wins over the
  // low limit, and both win over the zero mark.
  task automatic take_step(input bit up, output logic [1:0] turn, output logic [1:0] mark);
    if (up) begin
      step_total    = step_total + 1;
      latched_event = qkd_pkg::EVT_RIGHT;
      turn          = qkd_pkg::TURN_RIGHT;
    end else begin
      step_total    = step_total - 1;
      latched_event = qkd_pkg::EVT_LEFT;
      turn          = qkd_pkg::TURN_LEFT;
    end
    if (step_total >= upper_bound) begin
      latched_event = qkd_pkg::EVT_HIGH;
      mark          = qkd_pkg::MARK_HIGH;
    end else if (step_total <= lower_bound) begin
      latched_event = qkd_pkg::EVT_LOW;
      mark          = qkd_pkg::MARK_LOW;
    end else if (step_total == 0) begin
      latched_event = qkd_pkg::EVT_ZERO;
      mark          = qkd_pkg::MARK_ZERO;
    end else begin
      mark = qkd_pkg::MARK_NONE;
    end
  endtask

  // Advances the model by one accepted item and queues the result it owes.
  task automatic predict_item(input logic kind, input logic pin_a, input logic pin_b);
    knob_result_t owed;
    logic [1:0]   turn_code;
    logic [1:0]   mark_code;
    turn_code = qkd_pkg::TURN_NONE;
    mark_code = qkd_pkg::MARK_NONE;
    if (kind == KIND_CLEAR) begin
      // A clear touches only the count; debounce, mode and latch stay put.
      step_total = '0;
      clears_sent++;
    end else begin
      debounce_phase(pin_a, level_a, bounce_a, moved_a);
      debounce_phase(pin_b, level_b, bounce_b, moved_b);
      case (knob_mode)
        qkd_pkg::MODE_READY: begin
          // Phase A wins a tie; B's change stays pending for the next state.
          if (moved_a) begin
            moved_a   = 1'b0;
            knob_mode = qkd_pkg::MODE_PHA;
          end else if (moved_b) begin
            moved_b   = 1'b0;
            knob_mode = qkd_pkg::MODE_PHB;
          end else begin
            latched_event = qkd_pkg::EVT_NONE;
          end
        end
        qkd_pkg::MODE_PHA: begin
          if (moved_b) begin
            moved_b = 1'b0;
            take_step(!swap_sense, turn_code, mark_code);
            knob_mode = qkd_pkg::MODE_READY;
          end else if (moved_a) begin
            // The leading phase moved again: a glitch, no step.
            moved_a   = 1'b0;
            knob_mode = qkd_pkg::MODE_READY;
          end
        end
        qkd_pkg::MODE_PHB: begin
          if (moved_a) begin
            moved_a = 1'b0;
            take_step(swap_sense, turn_code, mark_code);
            knob_mode = qkd_pkg::MODE_READY;
          end else if (moved_b) begin
            moved_b   = 1'b0;
            knob_mode = qkd_pkg::MODE_READY;
          end
        end
        default: begin
          if (level_a && level_b) begin
            knob_mode = qkd_pkg::MODE_READY;
            moved_a   = 1'b0;
            moved_b   = 1'b0;
          end
        end
      endcase
    end
    owed.turn  = turn_code;
    owed.mark  = mark_code;
    owed.evt   = latched_event;
    owed.count = step_total;
    expected_results.push_back(owed);
    items_sent++;
  endtask

  // Offers one item, with random idle cycles ahead of it, and holds it until the
  // block takes it. tvalid stays high into the next item when no idle follows.
  task automatic send_item(input logic kind, input logic pin_a, input logic pin_b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, pin_b, pin_a};
    do @(posedge clk); while (!in_tready);
    predict_item(kind, pin_a, pin_b);
  endtask

  // Stops offering and waits until every owed result has been taken.
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drives one register write; the caller lowers cfg_we after the last one so
  // back-to-back writes never lower and raise the enable in the same step.
  task automatic write_reg(input logic [qkd_pkg::CFG_ADDR_BITS-1:0] idx,
                           input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      qkd_pkg::CFG_DEBOUNCE_TICKS: ticks_needed = value[7:0];
      qkd_pkg::CFG_DIRECTION_SWAP: swap_sense   = value[0];
      qkd_pkg::CFG_UPPER_LIMIT:    upper_bound  = value;
      qkd_pkg::CFG_LOWER_LIMIT:    lower_bound  = value;
      default: ;
    endcase
  endtask

  // Loads all four registers once the block has drained.
  task automatic apply_settings(input logic [7:0] ticks, input logic swap,
                                input logic [31:0] upper, input logic [31:0] lower);
    settle_idle();
    write_reg(qkd_pkg::CFG_DEBOUNCE_TICKS, {24'd0, ticks});
    write_reg(qkd_pkg::CFG_DIRECTION_SWAP, {31'd0, swap});
    write_reg(qkd_pkg::CFG_UPPER_LIMIT, upper);
    write_reg(qkd_pkg::CFG_LOWER_LIMIT, lower);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct <= receiver_pct;
  endtask

  // Turns the knob at random: mostly clean Gray-code steps that hold each level
  // long enough to pass the debounce, with direction changes, short bounces,
  // clears and a share of random noise samples mixed in.
  task automatic random_walk(input int item_total);
    int sent;
    int pick;
    int run_len;
    bit dir;
    bit pin_a, pin_b;
    bit next_a, next_b;
    sent  = 0;
    dir   = 1'($urandom_range(1));
    pin_a = level_a;
    pin_b = level_b;
    while (sent < item_total) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(KIND_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 10) begin
        send_item(KIND_SAMPLE, 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        if ($urandom_range(99) < 25) dir = ~dir;
        next_a = pin_a;
        next_b = pin_b;
        // With dir set, A leads: 11 -> 01 -> 00 -> 10 -> 11.
        if ((pin_a == pin_b) == dir) next_a = ~pin_a;
        else next_b = ~pin_b;
        // A bounce shows the new level for one sample only, shorter than the
        // debounce window, then falls back.
        if (ticks_needed > 1 && $urandom_range(99) < 15) begin
          send_item(KIND_SAMPLE, next_a, next_b);
          send_item(KIND_SAMPLE, pin_a, pin_b);
          sent += 2;
        end
        pin_a   = next_a;
        pin_b   = next_b;
        run_len = (ticks_needed == 0 ? 1 : int'(ticks_needed)) + $urandom_range(1);
        repeat (run_len) begin
          send_item(KIND_SAMPLE, pin_a, pin_b);
          sent++;
        end
      end
    end
  endtask

  // Reset defaults: waiting for both phases high, a right turn, a left turn back
  // to zero, a glitch on the leading phase, both phases changing together, and
  // clears whose pin levels must be ignored.
  task automatic test_directed_basics();
    send_item(KIND_SAMPLE, 1'b1, 1'b0);
    send_item(KIND_SAMPLE, 1'b1, 1'b1);
    send_item(KIND_SAMPLE, 1'b1, 1'b1);
    send_item(KIND_SAMPLE, 1'b0, 1'b1);
    send_item(KIND_SAMPLE, 1'b0, 1'b0);
    send_item(KIND_SAMPLE, 1'b0, 1'b1);
    send_item(KIND_SAMPLE, 1'b1, 1'b1);
    send_item(KIND_SAMPLE, 1'b0, 1'b1);
    send_item(KIND_SAMPLE, 1'b1, 1'b1);
    send_item(KIND_SAMPLE, 1'b0, 1'b0);
    send_item(KIND_SAMPLE, 1'b0, 1'b0);
    send_item(KIND_CLEAR, 1'b1, 1'b1);
    send_item(KIND_CLEAR, 1'b0, 1'b0);
  endtask

  // Tight limits so every mark shows up, then the swapped direction sense.
  task automatic test_directed_limits();
    apply_settings(8'd0, 1'b0, 32'sd1, -32'sd1);
    send_item(KIND_SAMPLE, 1'b1, 1'b0);
    send_item(KIND_SAMPLE, 1'b1, 1'b1);
    send_item(KIND_SAMPLE, 1'b1, 1'b0);
    send_item(KIND_SAMPLE, 1'b0, 1'b0);
    send_item(KIND_SAMPLE, 1'b0, 1'b1);
    send_item(KIND_SAMPLE, 1'b1, 1'b1);
    apply_settings(8'd0, 1'b1, 32'sd1, -32'sd1);
    send_item(KIND_SAMPLE, 1'b0, 1'b1);
    send_item(KIND_SAMPLE, 1'b0, 1'b0);
    send_item(KIND_SAMPLE, 1'b1, 1'b0);
    send_item(KIND_SAMPLE, 1'b1, 1'b1);
    send_item(KIND_SAMPLE, 1'b1, 1'b0);
    send_item(KIND_SAMPLE, 1'b0, 1'b0);
  endtask

  // The widest debounce window: a broken run must start over, and a full run of
  // 255 differing samples moves both phases at once.
  task automatic test_long_debounce();
    apply_settings(8'd255, 1'b0, 32'sd100, -32'sd100);
    set_idling(0, 0);
    repeat (100) send_item(KIND_SAMPLE, ~level_a, ~level_b);
    send_item(KIND_SAMPLE, level_a, level_b);
    repeat (255) send_item(KIND_SAMPLE, ~level_a, ~level_b);
    send_item(KIND_SAMPLE, level_a, level_b);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // result register fills and the block has to stall its input.
  task automatic test_backpressure();
    apply_settings(8'd1, 1'b0, 32'sd3, -32'sd3);
    set_idling(0, 0);
    hold_req <= hold_req + 1;
    random_walk(40);
  endtask

  task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                   input logic [7:0] ticks, input logic swap,
                                   input logic [31:0] upper, input logic [31:0] lower,
                                   input int item_total);
    apply_settings(ticks, swap, upper, lower);
    set_idling(sender_pct, receiver_pct);
    random_walk(item_total);
  endtask

  // Receiver side: random stalls at the current rate, or a counted hold-off when
  // one has been requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Every result item taken by the receiver is held against the oldest owed one.
  always @(posedge clk) begin
    knob_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item 0x%h arrived with nothing owed", out_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_tdata[1:0] !== want.turn) begin
          $error("turn: expected %0d, got %0d", want.turn, out_tdata[1:0]);
          error_count++;
        end
        if (out_tdata[3:2] !== want.mark) begin
          $error("mark: expected %0d, got %0d", want.mark, out_tdata[3:2]);
          error_count++;
        end
        if (out_tdata[6:4] !== want.evt) begin
          $error("last_event: expected %0d, got %0d", want.evt, out_tdata[6:4]);
          error_count++;
        end
        if (out_tdata[38:7] !== want.count) begin
          $error("count_out: expected %0d, got %0d", want.count, $signed(out_tdata[38:7]));
          error_count++;
        end
        if (want.turn != qkd_pkg::TURN_NONE) steps_seen++;
        marks_seen[want.mark]++;
      end
    end
  end

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_basics();
    test_directed_limits();
    test_long_debounce();
    test_backpressure();
    // Small random limits; the lower one is the complement of 0..5, so -1..-6.
    test_random_phase(0, 0, 8'd0, 1'b0, 32'($urandom_range(1, 6)),
                      ~32'($urandom_range(0, 5)), 180);
    // Limits at the far ends of the range: no mark but zero can fire.
    test_random_phase(50, 0, 8'd1, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 180);
    // Limits crossed over: every step lands on the high mark.
    test_random_phase(0, 50, 8'd3, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 180);
    // Both limits at zero: high at or above zero, low below it.
    test_random_phase(29, 29, 8'd2, 1'b1, 32'd0, 32'd0, 180);
    settle_idle();

    $display("Sent %0d items (%0d clears) over %0d register settings and four idling mixes,",
             items_sent, clears_sent, settings_used);
    $display("checked %0d results: %0d steps, %0d high, %0d low and %0d zero marks.",
             results_checked, steps_seen, marks_seen[qkd_pkg::MARK_HIGH],
             marks_seen[qkd_pkg::MARK_LOW], marks_seen[qkd_pkg::MARK_ZERO]);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
